>>> src/jerk_limited_step_rate_ramp_macros.svh
// Assertion macros shared by the ramp generator RTL.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef JERK_LIMITED_STEP_RATE_RAMP_MACROS_SVH
`define JERK_LIMITED_STEP_RATE_RAMP_MACROS_SVH

// Same-cycle implication.
`define JLSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JLSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/jlsr_pkg.sv
// Package for the jerk limited step rate ramp: beat types, register indexes,
// reset values, fixed-point constants and the sequencer states. No dependencies.
`timescale 1ns / 1ps

package jlsr_pkg;

  localparam int unsigned UPDATE_PERIOD_MS = 5;
  localparam logic [15:0] DT_Q16 = 16'(UPDATE_PERIOD_MS * 65536 / 1000);

  localparam int unsigned CFG_W  = 20;
  localparam int unsigned CFG_IW = 3;

  localparam logic [CFG_IW-1:0] CFG_RAMP_MODE   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_RATE    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MAX_RATE    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LINEAR_STEP = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ACCEL_LIMIT = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_JERK        = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_TICK_RATE   = 3'd6;

  localparam logic        RST_RAMP_MODE   = 1'b1;
  localparam logic [15:0] RST_MIN_RATE    = 16'd50;
  localparam logic [15:0] RST_MAX_RATE    = 16'd5000;
  localparam logic [15:0] RST_LINEAR_STEP = 16'd50;
  localparam logic [14:0] RST_ACCEL_LIMIT = 15'd4000;
  localparam logic [14:0] RST_JERK        = 15'd20000;
  localparam logic [19:0] RST_TICK_RATE   = 20'd20000;

  localparam logic        MODE_LINEAR = 1'b0;
  localparam logic        CMD_POT     = 1'b0;

  localparam logic [15:0] POT_FULL_SCALE = 16'd4095;

  localparam int unsigned DIV_W  = 20;
  localparam int unsigned DIV_SW = 5;
  localparam logic [DIV_SW-1:0] INT_STEPS = 5'd20;

  typedef struct packed {
    logic        command;
    logic [11:0] pot_reading;
    logic [15:0] requested_hz;
  } in_item_t;

  typedef struct packed {
    logic [15:0] current_hz;
    logic [15:0] target_hz;
    logic [19:0] interval_ticks;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_SW-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_RAMP_ACC,
    ST_RAMP_MUL,
    ST_RAMP_RATE,
    ST_INT_GO,
    ST_INT_DIV
  } state_t;

endpackage

>>> src/jlsr_div.sv
// Iterative restoring divider, one quotient bit per cycle, used for the
// timer interval. Uses jlsr_pkg.
`timescale 1ns / 1ps

module jlsr_div (
  input  logic                     clk,
  input  logic                     rst,
  input  jlsr_pkg::div_ctrl_t      ctrl,
  input  logic [jlsr_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]              divisor,
  output jlsr_pkg::div_stat_t      status,
  output logic [jlsr_pkg::DIV_W-1:0] quotient
);

  logic [jlsr_pkg::DIV_W-1:0]  quo;
  logic [15:0]                 rem;
  logic [15:0]                 dvs;
  logic [jlsr_pkg::DIV_SW-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [16:0]                 trial;
  logic [16:0]                 diff;
  logic                        ge;

  assign trial = {rem, quo[jlsr_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == {{(jlsr_pkg::DIV_SW-1){1'b0}}, 1'b1}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[jlsr_pkg::DIV_W-2:0], ge};
      rem <= ge ? diff[15:0] : trial[15:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

>>> src/jerk_limited_step_rate_ramp.sv
// Top level of the jerk limited step rate ramp: registers, sequencer and ramp datapath.
// Uses jlsr_pkg, the divider jlsr_div and the assertion macro header.
//
//   channel  signals                           direction
//   cmd      cmd_valid, cmd_stall, cmd_data    update beat in
//   res      res_valid, res_stall, res_data    result beat out
//   cfg      cfg_we, cfg_index, cfg_data       register write in
//
// One update beat is taken at a time. An accepted beat passes the potentiometer mapping
// for a potentiometer beat, the ramp step, an S-curve rate change where the rate must move,
// and the interval divider, one quotient bit per cycle, before its result beat appears.
// cmd_stall stays high from acceptance until the result beat is taken, and the next
// beat can be taken once the sequencer is back in its idle state. Reset is synchronous
// and restores the configuration and control registers, the rate of 50 Hz and zero acceleration.
`timescale 1ns / 1ps
`include "jerk_limited_step_rate_ramp_macros.svh"

module jerk_limited_step_rate_ramp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  jlsr_pkg::in_item_t          cmd_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output jlsr_pkg::out_item_t         res_data,
  input  logic                        cfg_we,
  input  logic [jlsr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [jlsr_pkg::CFG_W-1:0]  cfg_data
);

  jlsr_pkg::state_t state;
  jlsr_pkg::state_t state_next;

  logic        ramp_mode;
  logic [15:0] min_rate_hz;
  logic [15:0] max_rate_hz;
  logic [15:0] linear_step_hz;
  logic [14:0] accel_limit_hz_s;
  logic [14:0] jerk_hz_s2;
  logic [19:0] timer_tick_rate;

  logic [15:0]        rate_now;
  logic signed [31:0] accel_now;

  jlsr_pkg::in_item_t item;
  logic [15:0]        tgt;
  logic [30:0]        jerk_inc;
  logic signed [31:0] accel_new;
  logic signed [48:0] delta_prod;
  jlsr_pkg::out_item_t result;
  logic               res_done;

  logic [15:0] lo;
  logic [15:0] hi;
  logic [15:0] span;
  logic [15:0] req_clamped;
  logic        accept;

  logic [27:0] map_prod;
  logic [55:0] map_sum;
  logic [15:0] map_quo;

  jlsr_pkg::div_ctrl_t         div_ctrl;
  jlsr_pkg::div_stat_t         div_stat;
  logic [jlsr_pkg::DIV_W-1:0]  div_dividend;
  logic [15:0]                 div_divisor;
  logic [jlsr_pkg::DIV_W-1:0]  div_quotient;

  logic [16:0] lin_sum;
  logic [16:0] lin_val;
  logic [15:0] lin_rate;

  logic               up;
  logic signed [33:0] a_ext;
  logic signed [33:0] a_tgt;
  logic signed [33:0] js_ext;
  logic signed [33:0] a_step;
  logic signed [33:0] a_slew;
  logic signed [16:0] df_raw;
  logic signed [16:0] df;
  logic signed [19:0] nf;
  logic signed [19:0] nf_lim;
  logic               passed;
  logic [15:0]        s_rate;
  logic [19:0]        interval;

  assign accept = cmd_valid && !cmd_stall;

  assign lo          = (min_rate_hz == 16'd0) ? 16'd1 : min_rate_hz;
  assign hi          = (max_rate_hz > lo) ? max_rate_hz : lo;
  assign span        = hi - lo;
  assign req_clamped = (item.requested_hz < lo) ? lo :
                       ((item.requested_hz > hi) ? hi : item.requested_hz);

  // Division by 4095 as a multiplication by 2^28 + 2^16 + 2^4 + 1, which is
  // (2^40 + 4079) / 4095, and a shift by 40. It is exact for every product of
  // a 12-bit reading and a 16-bit span.
  assign map_sum = ({28'd0, map_prod} << 28) + ({28'd0, map_prod} << 16) +
                   ({28'd0, map_prod} << 4) + {28'd0, map_prod};
  assign map_quo = map_sum[55:40];

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_mode        <= jlsr_pkg::RST_RAMP_MODE;
      min_rate_hz      <= jlsr_pkg::RST_MIN_RATE;
      max_rate_hz      <= jlsr_pkg::RST_MAX_RATE;
      linear_step_hz   <= jlsr_pkg::RST_LINEAR_STEP;
      accel_limit_hz_s <= jlsr_pkg::RST_ACCEL_LIMIT;
      jerk_hz_s2       <= jlsr_pkg::RST_JERK;
      timer_tick_rate  <= jlsr_pkg::RST_TICK_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        jlsr_pkg::CFG_RAMP_MODE:   ramp_mode        <= cfg_data[0];
        jlsr_pkg::CFG_MIN_RATE:    min_rate_hz      <= cfg_data[15:0];
        jlsr_pkg::CFG_MAX_RATE:    max_rate_hz      <= cfg_data[15:0];
        jlsr_pkg::CFG_LINEAR_STEP: linear_step_hz   <= cfg_data[15:0];
        jlsr_pkg::CFG_ACCEL_LIMIT: accel_limit_hz_s <= cfg_data[14:0];
        jlsr_pkg::CFG_JERK:        jerk_hz_s2       <= cfg_data[14:0];
        jlsr_pkg::CFG_TICK_RATE:   timer_tick_rate  <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  // Linear ramp step.
  always_comb begin
    lin_sum = {1'b0, rate_now} + {1'b0, linear_step_hz};
    if (rate_now < tgt) begin
      lin_val = (lin_sum > {1'b0, tgt}) ? {1'b0, tgt} : lin_sum;
    end else if (rate_now > tgt) begin
      lin_val = (rate_now > linear_step_hz) ? {1'b0, rate_now - linear_step_hz} :
                                              {1'b0, lo};
    end else begin
      lin_val = {1'b0, rate_now};
    end
    if (lin_val < {1'b0, lo}) begin
      lin_val = {1'b0, lo};
    end
    if (lin_val > {1'b0, hi}) begin
      lin_val = {1'b0, hi};
    end
    lin_rate = (lin_val[15:0] == 16'd0) ? 16'd1 : lin_val[15:0];
  end

  // Acceleration slew toward the signed limit.
  always_comb begin
    up     = (tgt > rate_now);
    a_ext  = {{2{accel_now[31]}}, accel_now};
    a_tgt  = up ? $signed({3'b000, accel_limit_hz_s, 16'h0000}) :
                  -$signed({3'b000, accel_limit_hz_s, 16'h0000});
    js_ext = $signed({3'b000, jerk_inc});
    a_slew = a_ext;
    if (a_ext < a_tgt) begin
      a_step = a_ext + js_ext;
      a_slew = (a_step > a_tgt) ? a_tgt : a_step;
    end else if (a_ext > a_tgt) begin
      a_step = a_ext - js_ext;
      a_slew = (a_step < a_tgt) ? a_tgt : a_step;
    end else begin
      a_step = a_ext;
    end
  end

  // Rate integration with target stop and band clamp.
  always_comb begin
    df_raw = delta_prod[48:32];
    if (df_raw == 17'sd0) begin
      df = up ? 17'sd1 : -17'sd1;
    end else begin
      df = df_raw;
    end
    nf     = $signed({4'b0000, rate_now}) + $signed({{3{df[16]}}, df});
    passed = (up && (nf > $signed({4'b0000, tgt}))) ||
             (!up && (nf < $signed({4'b0000, tgt})));
    nf_lim = passed ? $signed({4'b0000, tgt}) : nf;
    if (nf_lim < $signed({4'b0000, lo})) begin
      nf_lim = $signed({4'b0000, lo});
    end
    if (nf_lim > $signed({4'b0000, hi})) begin
      nf_lim = $signed({4'b0000, hi});
    end
    s_rate = (nf_lim[15:0] == 16'd0) ? 16'd1 : nf_lim[15:0];
  end

  assign interval = (div_quotient == 20'd0) ? 20'd1 : div_quotient;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      jlsr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = jlsr_pkg::ST_MAP_MUL;
        end
      end
      jlsr_pkg::ST_MAP_MUL: begin
        state_next = (item.command == jlsr_pkg::CMD_POT) ? jlsr_pkg::ST_MAP_DIV :
                                                           jlsr_pkg::ST_RAMP_ACC;
      end
      jlsr_pkg::ST_MAP_DIV: state_next = jlsr_pkg::ST_RAMP_ACC;
      jlsr_pkg::ST_RAMP_ACC: begin
        if (ramp_mode == jlsr_pkg::MODE_LINEAR || tgt == rate_now) begin
          state_next = jlsr_pkg::ST_INT_GO;
        end else begin
          state_next = jlsr_pkg::ST_RAMP_MUL;
        end
      end
      jlsr_pkg::ST_RAMP_MUL:  state_next = jlsr_pkg::ST_RAMP_RATE;
      jlsr_pkg::ST_RAMP_RATE: state_next = jlsr_pkg::ST_INT_GO;
      jlsr_pkg::ST_INT_GO:    state_next = jlsr_pkg::ST_INT_DIV;
      jlsr_pkg::ST_INT_DIV: begin
        if (res_done && !res_stall) begin
          state_next = jlsr_pkg::ST_IDLE;
        end
      end
      default: state_next = jlsr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    cmd_stall      = (state != jlsr_pkg::ST_IDLE);
    div_ctrl.start = 1'b0;
    div_ctrl.steps = jlsr_pkg::INT_STEPS;
    div_dividend   = timer_tick_rate;
    div_divisor    = rate_now;
    case (state)
      jlsr_pkg::ST_INT_GO: begin
        div_ctrl.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jlsr_pkg::ST_IDLE;
      rate_now  <= jlsr_pkg::RST_MIN_RATE;
      accel_now <= '0;
      res_done  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        jlsr_pkg::ST_RAMP_ACC: begin
          if (ramp_mode == jlsr_pkg::MODE_LINEAR) begin
            rate_now <= lin_rate;
          end else if (tgt == rate_now) begin
            accel_now <= '0;
          end
        end
        jlsr_pkg::ST_RAMP_RATE: begin
          rate_now  <= s_rate;
          accel_now <= passed ? 32'sd0 : accel_new;
        end
        jlsr_pkg::ST_INT_DIV: begin
          if (div_stat.done) begin
            res_done <= 1'b1;
          end else if (res_done && !res_stall) begin
            res_done <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= cmd_data;
      jerk_inc <= 31'(jerk_hz_s2) * 31'(jlsr_pkg::DT_Q16);
    end
    case (state)
      jlsr_pkg::ST_MAP_MUL: begin
        tgt      <= req_clamped;
        map_prod <= 28'(item.pot_reading) * 28'(span);
      end
      jlsr_pkg::ST_MAP_DIV: begin
        tgt <= lo + map_quo;
      end
      jlsr_pkg::ST_RAMP_ACC: begin
        accel_new <= a_slew[31:0];
      end
      jlsr_pkg::ST_RAMP_MUL: begin
        delta_prod <= 49'(accel_new) * 49'($signed({1'b0, jlsr_pkg::DT_Q16}));
      end
      jlsr_pkg::ST_INT_DIV: begin
        if (div_stat.done) begin
          result.current_hz     <= rate_now;
          result.target_hz      <= tgt;
          result.interval_ticks <= interval;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid = res_done;
  assign res_data  = result;

  jlsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_quotient)
  );

  `JLSR_ASSERT_NXT(a_accept_starts, accept, state == jlsr_pkg::ST_MAP_MUL, "Accepted beat did not start the sequence.")
  `JLSR_ASSERT_IMP(a_rate_nonzero, 1'b1, rate_now != 16'd0, "Current rate reached zero.")
  `JLSR_ASSERT_IMP(a_interval_nonzero, res_valid, res_data.interval_ticks != 20'd0, "Interval of zero offered.")
  `JLSR_ASSERT_NXT(a_div_done_result, state == jlsr_pkg::ST_INT_DIV && div_stat.done, res_valid, "Interval finished without a result beat.")
  `JLSR_ASSERT_IMP(a_div_idle_at_accept, accept, !div_stat.busy, "Divider busy while a new beat was accepted.")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the jerk limited step rate ramp. A scoreboard class predicts
// every result beat from the accepted update beats and the register writes it has seen.
// Depends on jlsr_pkg and the jerk_limited_step_rate_ramp RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic CMD_REQUEST    = 1'b1;
  localparam logic MODE_SCURVE    = 1'b1;
  localparam int   QUIET_LIMIT    = 3000;
  localparam int   RX_HOLD_CYCLES = 300;
  localparam int   PHASE_BEATS    = 78;
  localparam int   PHASES         = 10;

  typedef struct packed {
    logic        mode;
    logic [15:0] min_hz;
    logic [15:0] max_hz;
    logic [15:0] step_hz;
    logic [14:0] accel;
    logic [14:0] jerk;
    logic [19:0] tick;
  } ramp_cfg_t;

  class ramp_scoreboard;
    logic        mode;
    logic [15:0] min_hz;
    logic [15:0] max_hz;
    logic [15:0] step_hz;
    logic [14:0] accel_lim;
    logic [14:0] jerk;
    logic [19:0] tick_rate;
    logic [15:0] rate_hz;
    int          accel_fix;
    jlsr_pkg::out_item_t expected_beats[$];
    int          failures;
    int          reported;

    function new();
      mode      = jlsr_pkg::RST_RAMP_MODE;
      min_hz    = jlsr_pkg::RST_MIN_RATE;
      max_hz    = jlsr_pkg::RST_MAX_RATE;
      step_hz   = jlsr_pkg::RST_LINEAR_STEP;
      accel_lim = jlsr_pkg::RST_ACCEL_LIMIT;
      jerk      = jlsr_pkg::RST_JERK;
      tick_rate = jlsr_pkg::RST_TICK_RATE;
      rate_hz   = jlsr_pkg::RST_MIN_RATE;
      accel_fix = 0;
      failures  = 0;
      reported  = 0;
    endfunction

    function void load_reg(logic [jlsr_pkg::CFG_IW-1:0] idx,
                           logic [jlsr_pkg::CFG_W-1:0] val);
      case (idx)
        jlsr_pkg::CFG_RAMP_MODE:   mode = val[0];
        jlsr_pkg::CFG_MIN_RATE:    min_hz = val[15:0];
        jlsr_pkg::CFG_MAX_RATE:    max_hz = val[15:0];
        jlsr_pkg::CFG_LINEAR_STEP: step_hz = val[15:0];
        jlsr_pkg::CFG_ACCEL_LIMIT: accel_lim = val[14:0];
        jlsr_pkg::CFG_JERK:        jerk = val[14:0];
        jlsr_pkg::CFG_TICK_RATE:   tick_rate = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Advances the ramp state by one update tick and queues the result it must produce.
    function void note_update(jlsr_pkg::in_item_t beat);
      longint      lo, hi, tgt, cur, err, at, a, df, step, dt;
      logic [19:0] interval;
      jlsr_pkg::out_item_t want;
      dt = longint'(jlsr_pkg::DT_Q16);
      lo = (min_hz != 0) ? longint'(min_hz) : 1;
      hi = (longint'(max_hz) > lo) ? longint'(max_hz) : lo;
      if (beat.command == jlsr_pkg::CMD_POT) begin
        tgt = lo + longint'(beat.pot_reading) * (hi - lo) /
                   longint'(jlsr_pkg::POT_FULL_SCALE);
      end else begin
        tgt = longint'(beat.requested_hz);
        if (tgt < lo) tgt = lo;
        else if (tgt > hi) tgt = hi;
      end
      cur = longint'(rate_hz);
      if (mode == jlsr_pkg::MODE_LINEAR) begin
        step = longint'(step_hz);
        if (cur < tgt) begin
          cur += step;
          if (cur > tgt) cur = tgt;
        end else if (cur > tgt) begin
          if (cur > step) cur -= step;
          else cur = lo;
        end
        if (cur < lo) cur = lo;
        if (cur > hi) cur = hi;
      end else begin
        err = tgt - cur;
        if (err == 0) begin
          accel_fix = 0;
        end else begin
          at = longint'(accel_lim) * 65536;
          if (err < 0) at = -at;
          step = longint'(jerk) * dt;
          a = longint'(accel_fix);
          if (a < at) begin
            a += step;
            if (a > at) a = at;
          end else if (a > at) begin
            a -= step;
            if (a < at) a = at;
          end
          // The rate change is floored, and a zero change still moves one hertz.
          df = (a * dt) >>> 32;
          if (df == 0) df = (err > 0) ? 1 : -1;
          cur += df;
          if ((err > 0 && cur > tgt) || (err < 0 && cur < tgt)) begin
            cur = tgt;
            a = 0;
          end
          if (cur < lo) cur = lo;
          if (cur > hi) cur = hi;
          accel_fix = int'(a);
        end
      end
      if (cur < 1) cur = 1;
      rate_hz = cur[15:0];
      interval = tick_rate / rate_hz;
      if (interval == 0) interval = 1;
      want.current_hz     = rate_hz;
      want.target_hz      = tgt[15:0];
      want.interval_ticks = interval;
      expected_beats.push_back(want);
    endfunction

    function void check_result(jlsr_pkg::out_item_t got);
      jlsr_pkg::out_item_t want;
      if (expected_beats.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result beat: current %0d target %0d interval %0d",
                   got.current_hz, got.target_hz, got.interval_ticks);
        end
        return;
      end
      want = expected_beats.pop_front();
      if (got.current_hz !== want.current_hz || got.target_hz !== want.target_hz ||
          got.interval_ticks !== want.interval_ticks) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch at %0t: want %0d/%0d/%0d got %0d/%0d/%0d",
                   $realtime, want.current_hz, want.target_hz, want.interval_ticks,
                   got.current_hz, got.target_hz, got.interval_ticks);
        end
      end
    endfunction

    function void close_out();
      if (expected_beats.size() != 0) begin
        failures += expected_beats.size();
        $display("%0d expected result beats never arrived", expected_beats.size());
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cmd_valid = 1'b0;
  logic                          cmd_stall;
  jlsr_pkg::in_item_t            cmd_data = '0;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  jlsr_pkg::out_item_t           res_data;
  logic                          cfg_we = 1'b0;
  logic [jlsr_pkg::CFG_IW-1:0]   cfg_index = '0;
  logic [jlsr_pkg::CFG_W-1:0]    cfg_data = '0;

  ramp_scoreboard ramp_sb = new();
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit rx_hold_req = 1'b0;
  int rx_stall_left = 0;
  int quiet_cycles = 0;

  jerk_limited_step_rate_ramp dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) ramp_sb.note_update(cmd_data);
      if (res_valid && !res_stall) ramp_sb.check_result(res_data);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // The receiver either follows its random stall pattern or, on request, holds off for a
  // long stretch so that the block fills up and stalls its update input.
  always begin
    @(posedge clk);
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      res_stall <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      res_stall <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      rx_stall_left = pick_gap(rx_idle);
    end
  end

  function automatic jlsr_pkg::in_item_t pot_beat(logic [11:0] pot);
    jlsr_pkg::in_item_t b;
    b.command      = jlsr_pkg::CMD_POT;
    b.pot_reading  = pot;
    b.requested_hz = 16'($urandom);
    return b;
  endfunction

  function automatic jlsr_pkg::in_item_t req_beat(logic [15:0] hz);
    jlsr_pkg::in_item_t b;
    b.command      = CMD_REQUEST;
    b.pot_reading  = 12'($urandom);
    b.requested_hz = hz;
    return b;
  endfunction

  function automatic jlsr_pkg::in_item_t random_update(ramp_cfg_t c);
    jlsr_pkg::in_item_t b;
    b.command     = 1'($urandom_range(0, 1));
    b.pot_reading = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 3))
      0: b.requested_hz = 16'($urandom);
      1: b.requested_hz = 16'($urandom_range(0, 40));
      default: b.requested_hz = 16'($urandom_range(c.min_hz, c.max_hz));
    endcase
    return b;
  endfunction

  function automatic ramp_cfg_t random_cfg();
    ramp_cfg_t c;
    c.mode    = 1'($urandom_range(0, 1));
    c.min_hz  = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 3000));
    c.max_hz  = 16'($urandom_range(1, 65535));
    c.step_hz = 16'($urandom_range(0, 2000));
    c.accel   = 15'($urandom_range(0, 32767));
    c.jerk    = 15'($urandom_range(0, 32767));
    c.tick    = 20'($urandom_range(0, 1000000));
    return c;
  endfunction

  task automatic send_update(jlsr_pkg::in_item_t b, int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_data  <= b;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic wait_drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (ramp_sb.pending() != 0);
  endtask

  task automatic write_cfg_reg(logic [jlsr_pkg::CFG_IW-1:0] idx,
                               logic [jlsr_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    ramp_sb.load_reg(idx, val);
  endtask

  task automatic apply_cfg(ramp_cfg_t c);
    write_cfg_reg(jlsr_pkg::CFG_RAMP_MODE, jlsr_pkg::CFG_W'(c.mode));
    write_cfg_reg(jlsr_pkg::CFG_MIN_RATE, jlsr_pkg::CFG_W'(c.min_hz));
    write_cfg_reg(jlsr_pkg::CFG_MAX_RATE, jlsr_pkg::CFG_W'(c.max_hz));
    write_cfg_reg(jlsr_pkg::CFG_LINEAR_STEP, jlsr_pkg::CFG_W'(c.step_hz));
    write_cfg_reg(jlsr_pkg::CFG_ACCEL_LIMIT, jlsr_pkg::CFG_W'(c.accel));
    write_cfg_reg(jlsr_pkg::CFG_JERK, jlsr_pkg::CFG_W'(c.jerk));
    write_cfg_reg(jlsr_pkg::CFG_TICK_RATE, c.tick);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // With the reset settings the rate already sits at the bottom of the band.
    send_update(pot_beat(12'd0), 0);
    repeat (3) send_update(pot_beat(12'd4095), 0);
    send_update(req_beat(16'hFFFF), 0);
    repeat (2) send_update(req_beat(16'd0), 0);
    repeat (2) send_update(req_beat(16'd2000), 0);
    send_update(pot_beat(12'hAAA), 0);
    send_update(pot_beat(12'h555), 0);
    send_update(req_beat(16'hAAAA), 0);
    send_update(req_beat(16'h5555), 0);
    wait_drain();
    apply_cfg('{jlsr_pkg::MODE_LINEAR, 16'd0, 16'd600, 16'd100, 15'd4000, 15'd20000, 20'd0});
    repeat (5) send_update(req_beat(16'd450), 0);
    // A full step down passes the target, then the rate falls to the band floor.
    send_update(req_beat(16'd420), 0);
    repeat (4) send_update(req_beat(16'd1), 0);
    repeat (2) send_update(pot_beat(12'd4095), 0);
  endtask

  initial begin
    ramp_cfg_t          plan[8];
    ramp_cfg_t          cfg;
    jlsr_pkg::in_item_t beat;
    int                 sent;
    int                 reps;
    int                 burst;
    plan[0] = '{MODE_SCURVE, 16'd50, 16'd5000, 16'd50, 15'd4000, 15'd20000, 20'd20000};
    plan[1] = '{MODE_SCURVE, 16'd100, 16'd400, 16'd50, 15'd32767, 15'd32767, 20'd1000000};
    plan[2] = '{jlsr_pkg::MODE_LINEAR, 16'd0, 16'd65535, 16'd1000, 15'd1, 15'd0, 20'hFFFFF};
    plan[3] = '{jlsr_pkg::MODE_LINEAR, 16'd700, 16'd600, 16'd0, 15'd1, 15'd1, 20'd0};
    plan[4] = '{MODE_SCURVE, 16'd65535, 16'd1, 16'd50, 15'd32767, 15'd0, 20'd1};
    plan[5] = '{jlsr_pkg::MODE_LINEAR, 16'd200, 16'd8000, 16'd65535, 15'd0, 15'd32767, 20'd1};
    plan[6] = '{MODE_SCURVE, 16'd1, 16'd65535, 16'd50, 15'd0, 15'd32767, 20'd1000000};
    plan[7] = '{MODE_SCURVE, 16'd10, 16'd200, 16'd1, 15'd32767, 15'd32767, 20'd123456};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      cfg = (p < 8) ? plan[p] : random_cfg();
      apply_cfg(cfg);
      tx_idle = (p != 0 && p != 5);
      rx_idle = (p != 0 && p != 7);
      sent = 0;
      burst = 0;
      // Mostly runs of one held command so the ramp settles, with single beats as noise.
      while (sent < PHASE_BEATS) begin
        beat = random_update(cfg);
        reps = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 30);
        for (int k = 0; k < reps && sent < PHASE_BEATS; k++) begin
          if (p == 1 && sent == 12) begin
            rx_hold_req = 1'b1;
            burst = 8;
          end
          send_update(beat, (burst > 0) ? 0 : pick_gap(tx_idle));
          if (burst > 0) burst--;
          sent++;
        end
        if ($urandom_range(0, 9) == 0) wait_drain();
      end
    end
    wait_drain();
    repeat (100) @(posedge clk);
    ramp_sb.close_out();
    if (ramp_sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
